// ----- hw/rtl/tse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tse_pkg
// Shared word types, header offsets and character codes for the tar stream
// entry extractor.
// ----------------------------------------------------------------------------
package tse_pkg;

   // Archive geometry
   localparam int         BLOCK_BYTES = 512;
   localparam int         SIZE_DIGITS = 12;
   localparam int         SIZE_WIDTH  = 36;
   localparam int         OFF_WIDTH   = 9;

   localparam logic [OFF_WIDTH-1:0] NAME_BYTES  = 9'd100;
   localparam logic [OFF_WIDTH-1:0] SIZE_OFFSET = 9'd124;
   localparam logic [OFF_WIDTH-1:0] SIZE_END    = OFF_WIDTH'(124 + SIZE_DIGITS);
   localparam logic [OFF_WIDTH-1:0] TYPE_OFFSET = 9'd156;
   localparam logic [OFF_WIDTH-1:0] LAST_OFFSET = OFF_WIDTH'(BLOCK_BYTES - 1);

   // Character codes
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_SEVEN  = 8'h37;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_ACCEPT  = 2'd1;
   localparam logic [1:0] KIND_SKIP    = 2'd2;
   localparam logic [1:0] KIND_END     = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_word_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [7:0]            payload_byte;
      logic [SIZE_WIDTH-1:0] entry_size;
      logic                  entry_end;
      logic                  truncated;
      logic [15:0]           restored_count;
   } rsp_word_type;

   // Header scanner status toward the sequencer
   typedef struct packed {
      logic                  last_byte;   // this byte closes the header block
      logic                  all_zero;    // whole header was zero
      logic                  safe;        // name and type checks passed
      logic [SIZE_WIDTH-1:0] size_next;   // size including this byte
      logic [SIZE_WIDTH-1:0] size_held;   // size of the current entry
   } hdr_status_type;

endpackage

// ----- hw/rtl/tar_stream_entry_extractor_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tar_stream_entry_extractor_core
// Byte-serial tar archive reader: deframes headers and payloads, emits the
// payload of safe entries and reports skipped entries and archive end.
// ----------------------------------------------------------------------------
//
//   channel  dir  word type      moves
//   req_     in   req_word_type  one archive byte plus end-of-stream mark
//   rsp_     out  rsp_word_type  zero or one result per archive byte
//
// One byte enters per cycle unless rsp_ stalls: it waits in the input register,
// is processed in the cycle it advances and its result lands in the result
// register, so rsp_valid rises once the byte has passed both registers; the
// phase/counter update loop sets the rate. A stall on rsp_ (result register
// full, rsp_ready low) holds the input byte; req_ready drops only when both
// registers are full. Synchronous reset, and any byte marked stream_end,
// return the reader state.
module tar_stream_entry_extractor_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tse_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tse_pkg::rsp_word_type rsp_data
);
   import tse_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_PAYLOAD,
      PH_SKIP,
      PH_PAD,
      PH_END
   } phase_type;

   // input register
   logic         in_valid_ff, in_valid_in;
   req_word_type in_data_ff;

   // sequencer state
   phase_type             phase_ff, phase_in;
   logic [SIZE_WIDTH-1:0] remain_ff, remain_in;
   logic [OFF_WIDTH-1:0]  pad_ff, pad_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic                   advance;
   logic                   out_free;
   logic                   last;
   logic                   hdr_step;
   hdr_status_type         hdr;
   logic [SIZE_WIDTH-1:0]  remain_dec;
   logic [OFF_WIDTH-1:0]   pad_dec;
   logic [COUNT_WIDTH-1:0] count_upd;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic [31:0]            count_wide;
   logic                   res_valid;
   rsp_word_type           res;

   // advance the held byte when the result register can take its result
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign last      = in_data_ff.stream_end;
   assign hdr_step  = advance && (phase_ff == PH_HEADER);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   tse_hdr_scan u_hdr (
      .clock     (clock),
      .reset     (reset),
      .step      (hdr_step),
      .restart   (advance && last),
      .data_byte (in_data_ff.data_byte),
      .status    (hdr)
   );

   always_comb begin
      remain_dec = remain_ff - 1'b1;
      pad_dec    = (pad_ff != '0) ? pad_ff - 1'b1 : pad_ff;
      count_inc  = (count_ff != '1) ? count_ff + 1'b1 : count_ff;

      phase_in  = phase_ff;
      remain_in = remain_ff;
      pad_in    = pad_ff;
      count_upd = count_ff;
      res_valid = 1'b0;

      res.kind         = KIND_PAYLOAD;
      res.payload_byte = '0;
      res.entry_size   = '0;
      res.entry_end    = 1'b0;
      res.truncated    = 1'b0;

      case (phase_ff)
         PH_HEADER: begin
            if (hdr.last_byte) begin
               res_valid = 1'b1;
               if (hdr.all_zero) begin
                  phase_in = PH_END;
                  res.kind = KIND_END;
               end else if (hdr.safe) begin
                  res.kind = KIND_ACCEPT;
                  if (hdr.size_next == '0) begin
                     // empty entry counts as delivered right away
                     count_upd     = count_inc;
                     res.entry_end = 1'b1;
                  end else begin
                     remain_in      = hdr.size_next;
                     phase_in       = PH_PAYLOAD;
                     res.entry_size = hdr.size_next;
                     res.truncated  = last;
                  end
               end else begin
                  res.kind       = KIND_SKIP;
                  res.entry_size = hdr.size_next;
                  remain_in      = hdr.size_next;
                  // pad to the next block boundary
                  pad_in         = OFF_WIDTH'(0) - hdr.size_next[OFF_WIDTH-1:0];
                  phase_in       = (hdr.size_next != '0) ? PH_SKIP : PH_HEADER;
               end
            end
         end
         PH_PAYLOAD: begin
            res_valid        = 1'b1;
            res.payload_byte = in_data_ff.data_byte;
            res.entry_size   = hdr.size_held;
            remain_in        = remain_dec;
            if (remain_dec == '0) begin
               count_upd     = count_inc;
               res.entry_end = 1'b1;
               pad_in        = OFF_WIDTH'(0) - hdr.size_held[OFF_WIDTH-1:0];
               phase_in      = (pad_in != '0) ? PH_PAD : PH_HEADER;
            end else begin
               res.truncated = last;
            end
         end
         PH_SKIP: begin
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               phase_in = (pad_ff != '0) ? PH_PAD : PH_HEADER;
            end
         end
         PH_PAD: begin
            pad_in = pad_dec;
            if (pad_dec == '0) begin
               phase_in = PH_HEADER;
            end
         end
         PH_END: begin
            // drop bytes until the stream ends
         end
         default: begin
            phase_in = PH_HEADER;
         end
      endcase

      count_wide         = 32'(count_upd);
      res.restored_count = count_wide[15:0];
      count_in           = count_upd;

      // end of stream: return to the reset state for the next archive
      if (last) begin
         phase_in  = PH_HEADER;
         remain_in = '0;
         pad_in    = '0;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_HEADER;
         remain_ff   <= '0;
         pad_ff      <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            phase_ff  <= phase_in;
            remain_ff <= remain_in;
            pad_ff    <= pad_in;
            count_ff  <= count_in;
         end
      end
   end

   tse_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_valid (res_valid),
      .load_data  (res),
      .free       (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- hw/rtl/tse_hdr_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tse_hdr_scan
// Header byte scanner: tracks the offset in the header block, checks the
// name and type byte, and parses the octal size field.
// ----------------------------------------------------------------------------
module tse_hdr_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    restart,
   input  logic [7:0]              data_byte,
   output tse_pkg::hdr_status_type status
);
   import tse_pkg::*;

   logic [OFF_WIDTH-1:0]  off_ff, off_in;
   logic                  name_ended_ff, name_ended_in;
   logic                  name_empty_ff, name_empty_in;
   logic                  prev_dot_ff, prev_dot_in;
   logic                  name_bad_ff, name_bad_in;
   logic [SIZE_WIDTH-1:0] acc_ff, acc_in;
   logic                  stopped_ff, stopped_in;
   logic                  type_ok_ff, type_ok_in;
   logic                  all_zero_ff, all_zero_in;

   logic                  first;
   logic                  is_digit;

   always_comb begin
      first    = (off_ff == '0);
      is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_SEVEN);

      // start from cleared flags on the first byte of a block
      name_ended_in = first ? 1'b0 : name_ended_ff;
      name_empty_in = first ? 1'b0 : name_empty_ff;
      prev_dot_in   = first ? 1'b0 : prev_dot_ff;
      name_bad_in   = first ? 1'b0 : name_bad_ff;
      acc_in        = first ? '0   : acc_ff;
      stopped_in    = first ? 1'b0 : stopped_ff;
      type_ok_in    = first ? 1'b0 : type_ok_ff;
      all_zero_in   = (first ? 1'b1 : all_zero_ff) && (data_byte == CHAR_NUL);

      if ((off_ff < NAME_BYTES) && !name_ended_in) begin
         if (data_byte == CHAR_NUL) begin
            name_ended_in = 1'b1;
            if (first) begin
               name_empty_in = 1'b1;
            end
         end else begin
            if ((data_byte == CHAR_SLASH) || (data_byte == CHAR_BSLASH) ||
                ((data_byte == CHAR_DOT) && prev_dot_in)) begin
               name_bad_in = 1'b1;
            end
            prev_dot_in = (data_byte == CHAR_DOT);
         end
      end

      if ((off_ff >= SIZE_OFFSET) && (off_ff < SIZE_END) && !stopped_in) begin
         if (is_digit) begin
            acc_in = {acc_in[SIZE_WIDTH-4:0], 3'b000} + {33'd0, data_byte[2:0]};
         end else if ((data_byte != CHAR_SPACE) && (data_byte != CHAR_NUL)) begin
            stopped_in = 1'b1;
         end
      end

      if (off_ff == TYPE_OFFSET) begin
         type_ok_in = (data_byte == CHAR_ZERO) || (data_byte == CHAR_NUL);
      end

      off_in = (off_ff >= LAST_OFFSET) ? '0 : off_ff + 1'b1;

      status.last_byte = (off_ff >= LAST_OFFSET);
      status.all_zero  = all_zero_in;
      status.safe      = type_ok_in && !name_empty_in && !name_bad_in;
      status.size_next = acc_in;
      status.size_held = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         off_ff        <= '0;
         name_ended_ff <= 1'b0;
         name_empty_ff <= 1'b0;
         prev_dot_ff   <= 1'b0;
         name_bad_ff   <= 1'b0;
         acc_ff        <= '0;
         stopped_ff    <= 1'b0;
         type_ok_ff    <= 1'b0;
         all_zero_ff   <= 1'b1;
      end else if (step) begin
         off_ff        <= off_in;
         name_ended_ff <= name_ended_in;
         name_empty_ff <= name_empty_in;
         prev_dot_ff   <= prev_dot_in;
         name_bad_ff   <= name_bad_in;
         acc_ff        <= acc_in;
         stopped_ff    <= stopped_in;
         type_ok_ff    <= type_ok_in;
         all_zero_ff   <= all_zero_in;
      end
   end

endmodule

// ----- hw/rtl/tse_rsp_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tse_rsp_reg
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module tse_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  load_valid,
   input  tse_pkg::rsp_word_type load_data,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tse_pkg::rsp_word_type rsp_data
);
   import tse_pkg::*;

   logic         valid_ff;
   rsp_word_type data_ff;

   assign free      = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= load_valid;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_valid) begin
         data_ff <= load_data;
      end
   end

endmodule

// ----- hw/rtl/tse_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tse_checker
// Port-level checks on the tar stream entry extractor result channel.
// ----------------------------------------------------------------------------
module tse_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input tse_pkg::rsp_word_type rsp_data
);
   import tse_pkg::*;

   // stalled result word holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // nothing comes out in the cycle after reset
   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // only payload words carry a data byte
   a_byte_only_payload : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != KIND_PAYLOAD) |-> rsp_data.payload_byte == '0)
      else $error("data byte on a non-payload word");

   // archive end carries no size, end mark or truncation
   a_end_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_END) |->
         (rsp_data.entry_size == '0) && !rsp_data.entry_end && !rsp_data.truncated)
      else $error("archive end word carries entry fields");

   // a result side that can move never blocks the input
   a_ready_when_free : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input blocked while the result side was free");

endmodule

bind tar_stream_entry_extractor_core tse_checker u_tse_checker (.*);
